// File: hw/rtl/vscm_pkg.sv
package vscm_pkg;

  // Fixed-point format of the per-axis scale factors (unsigned Q8.FRAC_BITS).
  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 8;
  localparam int FACT_W    = FRAC_BITS + INT_BITS;

  // Field widths.
  localparam int MODE_W  = 3;
  localparam int SIZE_W  = 13;
  localparam int POINT_W = 12;
  localparam int OUT_W   = 16;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  // Datapath widths, all derived from the ones above.
  localparam int RAT_W  = 2 * SIZE_W;               // size products
  localparam int OFF_W  = FACT_W + SIZE_W + 1;      // signed doubled offset
  localparam int DSOR_W = FACT_W + SIZE_W + 1;      // 2 * d * f
  localparam int NUM_W  = OFF_W + 1;                // signed numerator
  localparam int MAG_W  = NUM_W - 1;                // numerator magnitude
  localparam int PROD_W = MAG_W + SIZE_W;           // magnitude times source size
  localparam int QBITS  = OUT_W;                    // quotient bits per item
  localparam int DIV_W  = DSOR_W + QBITS;           // divider remainder width
  localparam int LAT    = QBITS + 5;                // pipeline depth in stages

  localparam logic [FACT_W-1:0] ONE_Q    = FACT_W'(1) << FRAC_BITS;
  localparam logic [FACT_W-1:0] FACT_MAX = '1;

  // Register map, index = byte address / 4.
  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_SRC_W  = 3'd1,
    REG_SRC_H  = 3'd2,
    REG_DISP_W = 3'd3,
    REG_DISP_H = 3'd4
  } reg_idx_t;

  // Scaling modes; the two unused codes behave as stretch.
  typedef enum logic [MODE_W-1:0] {
    MODE_STRETCH  = 3'd0,
    MODE_PIXEL    = 3'd1,
    MODE_KEEP_ALL = 3'd2,
    MODE_FILL     = 3'd3,
    MODE_HEIGHT   = 3'd4,
    MODE_WIDTH    = 3'd5
  } scale_mode_t;

  // Factor setup sequencer states.
  typedef enum logic [2:0] {
    ST_PREP,
    ST_SEL_X,
    ST_DIV_X,
    ST_SEL_Y,
    ST_DIV_Y,
    ST_MUL_X,
    ST_MUL_Y,
    ST_IDLE
  } setup_state_t;

  // Raw register contents.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] src_w;
    logic [SIZE_W-1:0] src_h;
    logic [SIZE_W-1:0] disp_w;
    logic [SIZE_W-1:0] disp_h;
  } cfg_regs_t;

  // Per-axis constants used by the mapping pipeline.
  typedef struct packed {
    logic signed [OFF_W-1:0] off2;   // (1 - f) * d in Q.FRAC_BITS
    logic [DSOR_W-1:0]       dsor;   // 2 * d * f in Q.FRAC_BITS
    logic [SIZE_W-1:0]       size;   // source size along the axis
  } axis_cfg_t;

  // One mapped result.
  typedef struct packed {
    logic signed [OUT_W-1:0] mapped_x;
    logic signed [OUT_W-1:0] mapped_y;
    logic                    saturated;
  } result_t;

endpackage

// File: hw/rtl/vscm_regs.sv
module vscm_regs
  import vscm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output cfg_regs_t         regs,
  output logic              cfg_write
);

  reg_idx_t idx;

  assign idx       = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg_write = psel && penable && pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode   <= MODE_KEEP_ALL;
      regs.src_w  <= SIZE_W'(1);
      regs.src_h  <= SIZE_W'(1);
      regs.disp_w <= SIZE_W'(1);
      regs.disp_h <= SIZE_W'(1);
    end else if (cfg_write) begin
      unique case (idx)
        REG_MODE:   regs.mode   <= pwdata[MODE_W-1:0];
        REG_SRC_W:  regs.src_w  <= pwdata[SIZE_W-1:0];
        REG_SRC_H:  regs.src_h  <= pwdata[SIZE_W-1:0];
        REG_DISP_W: regs.disp_w <= pwdata[SIZE_W-1:0];
        REG_DISP_H: regs.disp_h <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = CFG_DW'(regs.mode);
      REG_SRC_W:  prdata = CFG_DW'(regs.src_w);
      REG_SRC_H:  prdata = CFG_DW'(regs.src_h);
      REG_DISP_W: prdata = CFG_DW'(regs.disp_w);
      REG_DISP_H: prdata = CFG_DW'(regs.disp_h);
      default:    prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/vscm_setup.sv
module vscm_setup
  import vscm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t regs,
  input  logic      cfg_write,
  output logic      busy,
  output axis_cfg_t cfg_x,
  output axis_cfg_t cfg_y
);

  localparam int SDIV_W = RAT_W + FACT_W;
  localparam int OVF_W  = RAT_W + INT_BITS;
  localparam int CNT_W  = $clog2(FACT_W);

  setup_state_t state, state_next;

  logic [MODE_W-1:0] mode_r;
  logic [SIZE_W-1:0] sw, sh, dw, dh;
  logic [RAT_W-1:0]  pa, pb;
  logic              narrow;

  logic              need_x, need_y;
  logic [RAT_W-1:0]  num_x, den_x, num_y, den_y;
  logic [RAT_W-1:0]  ld_num, ld_den;
  logic              ld_ovf;

  logic [SDIV_W-1:0] rem, dsh, rem_step;
  logic [FACT_W-1:0] quo, quo_step;
  logic [CNT_W-1:0]  cnt;
  logic              ovf;
  logic              ge;

  logic [FACT_W-1:0] fx, fy;
  logic [FACT_W-1:0] mul_f;
  logic [SIZE_W-1:0] mul_d;
  logic signed [FACT_W:0] one_minus;
  logic signed [OFF_W:0]  off_full;
  logic [SIZE_W+FACT_W-1:0] df;

  // A size of zero counts as one.
  function automatic logic [SIZE_W-1:0] size_of(input logic [SIZE_W-1:0] v);
    return (v == '0) ? SIZE_W'(1) : v;
  endfunction

  // Clamp a quotient to the factor range.
  function automatic logic [FACT_W-1:0] finish(input logic [FACT_W-1:0] qv, input logic ov);
    if (ov) begin
      return FACT_MAX;
    end else if (qv == '0) begin
      return FACT_W'(1);
    end
    return qv;
  endfunction

  // The display is narrower than the source when dw*sh < sw*dh.
  assign narrow = pb < pa;

  // Ratio selection for each axis by scaling mode.
  always_comb begin
    need_x = 1'b0;
    num_x  = pa;
    den_x  = pb;
    need_y = 1'b0;
    num_y  = pb;
    den_y  = pa;
    unique case (mode_r)
      MODE_PIXEL: begin
        need_x = 1'b1;
        num_x  = RAT_W'(sw);
        den_x  = RAT_W'(dw);
        need_y = 1'b1;
        num_y  = RAT_W'(sh);
        den_y  = RAT_W'(dh);
      end
      MODE_KEEP_ALL: begin
        need_x = !narrow;
        need_y = narrow;
      end
      MODE_FILL: begin
        need_x = narrow;
        need_y = !narrow;
      end
      MODE_HEIGHT: need_x = 1'b1;
      MODE_WIDTH:  need_y = 1'b1;
      default: ;
    endcase
  end

  // Shared divider: load operands and one quotient bit per cycle.
  assign ld_num   = (state == ST_SEL_Y) ? num_y : num_x;
  assign ld_den   = (state == ST_SEL_Y) ? den_y : den_x;
  assign ld_ovf   = OVF_W'(ld_num) >= (OVF_W'(ld_den) << INT_BITS);
  assign ge       = rem >= dsh;
  assign rem_step = ge ? rem - dsh : rem;
  assign quo_step = {quo[FACT_W-2:0], ge};

  // Offset and divisor products, one axis per cycle.
  assign mul_f     = (state == ST_MUL_Y) ? fy : fx;
  assign mul_d     = (state == ST_MUL_Y) ? dh : dw;
  assign one_minus = $signed({1'b0, ONE_Q}) - $signed({1'b0, mul_f});
  assign off_full  = one_minus * $signed({1'b0, mul_d});
  assign df        = mul_d * mul_f;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PREP;
    end else begin
      state <= state_next;
    end
  end

  // Next state; any register write restarts the computation.
  always_comb begin
    state_next = state;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_PREP:  state_next = ST_SEL_X;
      ST_SEL_X: state_next = need_x ? ST_DIV_X : ST_SEL_Y;
      ST_DIV_X: begin
        if (cnt == '0) begin
          state_next = ST_SEL_Y;
        end
      end
      ST_SEL_Y: state_next = need_y ? ST_DIV_Y : ST_MUL_X;
      ST_DIV_Y: begin
        if (cnt == '0) begin
          state_next = ST_MUL_X;
        end
      end
      ST_MUL_X: state_next = ST_MUL_Y;
      ST_MUL_Y: state_next = ST_IDLE;
      ST_IDLE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
    if (cfg_write) begin
      state_next = ST_PREP;
    end
  end

  // Datapath registers driven by the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      ST_PREP: begin
        mode_r <= regs.mode;
        sw     <= size_of(regs.src_w);
        sh     <= size_of(regs.src_h);
        dw     <= size_of(regs.disp_w);
        dh     <= size_of(regs.disp_h);
        pa     <= RAT_W'(size_of(regs.src_w)) * RAT_W'(size_of(regs.disp_h));
        pb     <= RAT_W'(size_of(regs.src_h)) * RAT_W'(size_of(regs.disp_w));
      end
      ST_SEL_X, ST_SEL_Y: begin
        rem <= SDIV_W'(ld_num) << FRAC_BITS;
        dsh <= SDIV_W'(ld_den) << (FACT_W - 1);
        quo <= '0;
        cnt <= CNT_W'(FACT_W - 1);
        ovf <= ld_ovf;
        if (state == ST_SEL_X && !need_x) begin
          fx <= ONE_Q;
        end
        if (state == ST_SEL_Y && !need_y) begin
          fy <= ONE_Q;
        end
      end
      ST_DIV_X, ST_DIV_Y: begin
        rem <= rem_step;
        dsh <= dsh >> 1;
        quo <= quo_step;
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          if (state == ST_DIV_X) begin
            fx <= finish(quo_step, ovf);
          end else begin
            fy <= finish(quo_step, ovf);
          end
        end
      end
      ST_MUL_X: begin
        cfg_x.off2 <= $signed(off_full[OFF_W-1:0]);
        cfg_x.dsor <= {df, 1'b0};
        cfg_x.size <= sw;
      end
      ST_MUL_Y: begin
        cfg_y.off2 <= $signed(off_full[OFF_W-1:0]);
        cfg_y.dsor <= {df, 1'b0};
        cfg_y.size <= sh;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/vscm_axis.sv
module vscm_axis
  import vscm_pkg::*;
(
  input  logic                    clk,
  input  logic                    ce,
  input  logic [POINT_W-1:0]      point,
  input  axis_cfg_t               cfg,
  output logic signed [OUT_W-1:0] mapped,
  output logic                    sat
);

  localparam int LO_W = MAG_W / 2;
  localparam int HI_W = MAG_W - LO_W;
  localparam logic [QBITS-1:0] HALF = QBITS'(1) << (QBITS - 1);
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic signed [NUM_W-1:0] pos_term, num;

  logic                     s1_neg;
  logic [MAG_W-1:0]         s1_mag;
  logic                     s2_neg;
  logic [LO_W+SIZE_W-1:0]   s2_lo;
  logic [HI_W+SIZE_W-1:0]   s2_hi;
  logic                     s3_neg;
  logic [PROD_W-1:0]        s3_prod;

  logic [DIV_W-1:0] rem [0:QBITS];
  logic [QBITS-1:0] quo [0:QBITS];
  logic             neg [0:QBITS];
  logic             ovf [0:QBITS];

  logic [QBITS-1:0] q;

  // Stage 1: subtract the doubled centering offset, split sign and magnitude.
  assign pos_term = NUM_W'({point, {(FRAC_BITS+1){1'b0}}});
  assign num      = pos_term - NUM_W'(cfg.off2);

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_neg <= num[NUM_W-1];
      s1_mag <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    end
  end

  // Stage 2: magnitude times source size as two partial products.
  always_ff @(posedge clk) begin
    if (ce) begin
      s2_neg <= s1_neg;
      s2_lo  <= s1_mag[LO_W-1:0] * cfg.size;
      s2_hi  <= s1_mag[MAG_W-1:LO_W] * cfg.size;
    end
  end

  // Stage 3: combine the partial products.
  always_ff @(posedge clk) begin
    if (ce) begin
      s3_neg  <= s2_neg;
      s3_prod <= (PROD_W'(s2_hi) << LO_W) + PROD_W'(s2_lo);
    end
  end

  // Stage 4: quotients too large for the output word are flagged up front.
  always_ff @(posedge clk) begin
    if (ce) begin
      rem[0] <= DIV_W'(s3_prod);
      quo[0] <= '0;
      neg[0] <= s3_neg;
      ovf[0] <= DIV_W'(s3_prod) >= (DIV_W'(cfg.dsor) << QBITS);
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar i = 0; i < QBITS; i++) begin : g_div
    logic [DIV_W-1:0] shd;
    logic             bit_ge;

    assign shd    = DIV_W'(cfg.dsor) << (QBITS - 1 - i);
    assign bit_ge = rem[i] >= shd;

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[i+1] <= bit_ge ? rem[i] - shd : rem[i];
        quo[i+1] <= {quo[i][QBITS-2:0], bit_ge};
        neg[i+1] <= neg[i];
        ovf[i+1] <= ovf[i];
      end
    end
  end

  // Last stage: restore the sign and saturate to the output range.
  assign q = quo[QBITS];

  always_ff @(posedge clk) begin
    if (ce) begin
      if (neg[QBITS]) begin
        if (ovf[QBITS] || q > HALF) begin
          mapped <= OUT_MIN;
          sat    <= 1'b1;
        end else begin
          mapped <= $signed(OUT_W'(0) - q);
          sat    <= 1'b0;
        end
      end else begin
        if (ovf[QBITS] || q[QBITS-1]) begin
          mapped <= OUT_MAX;
          sat    <= 1'b1;
        end else begin
          mapped <= $signed(q);
          sat    <= 1'b0;
        end
      end
    end
  end

endmodule

// File: hw/rtl/vscm_skid.sv
module vscm_skid
  import vscm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t in_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    sk_valid;
  result_t sk_data;
  logic    pop;

  assign pop  = out_valid && out_ready;
  assign full = sk_valid;

  // Valid flags of the output register and the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (sk_valid) begin
      if (pop) begin
        sk_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        sk_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Payload moves; no push arrives while the skid register is occupied.
  always_ff @(posedge clk) begin
    if (sk_valid) begin
      if (pop) begin
        out_data <= sk_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        sk_data <= in_data;
      end else begin
        out_data <= in_data;
      end
    end
  end

endmodule

// File: hw/rtl/viewport_scale_coordinate_map.sv
// Maps a pointer position on the display viewport back onto the source image grid
// for the configured scaling mode, truncating toward zero and saturating to 16 signed
// bits. Once set up, the block takes one beat per clock while the skid register is
// free; each beat passes through the mapping pipeline (offset subtract,
// split multiply, overflow check, one stage per quotient bit, saturation). Results
// leave through an output register backed by a skid register, so input beats keep
// flowing while one finished result waits. After reset and after every register
// write the per-axis scale factors are recomputed by a shared bit-serial divider
// (one factor bit per cycle): s_axis_tready stays low while they are recomputed,
// and each division that the mode needs lengthens that time. Registers are at byte
// addresses 0 (mode), 4 (source width), 8 (source height), 12 (display width) and
// 16 (display height); write them only while no beat is in flight.
module viewport_scale_coordinate_map
  import vscm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // point_x [11:0], point_y [23:12]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // mapped_x [15:0], mapped_y [31:16]
  output logic [0:0]        m_axis_tuser    // saturated [0]
);

  cfg_regs_t regs;
  logic      cfg_write;
  logic      busy;
  axis_cfg_t cfg_x, cfg_y;

  logic           ce;
  logic           accept;
  logic [LAT-1:0] vld;
  logic           full;
  result_t        res, out_res;

  logic                    sat_x, sat_y;
  logic signed [OUT_W-1:0] map_x, map_y;

  assign pready = 1'b1;

  vscm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .regs      (regs),
    .cfg_write (cfg_write)
  );

  vscm_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .cfg_write (cfg_write),
    .busy      (busy),
    .cfg_x     (cfg_x),
    .cfg_y     (cfg_y)
  );

  // The pipeline advances whenever the skid register is free.
  assign ce            = !full;
  assign s_axis_tready = ce && !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  vscm_axis u_axis_x (
    .clk    (clk),
    .ce     (ce),
    .point  (s_axis_tdata[POINT_W-1:0]),
    .cfg    (cfg_x),
    .mapped (map_x),
    .sat    (sat_x)
  );

  vscm_axis u_axis_y (
    .clk    (clk),
    .ce     (ce),
    .point  (s_axis_tdata[2*POINT_W-1:POINT_W]),
    .cfg    (cfg_y),
    .mapped (map_y),
    .sat    (sat_y)
  );

  // Either axis clamping marks the whole result.
  assign res = '{mapped_x: map_x, mapped_y: map_y, saturated: sat_x || sat_y};

  vscm_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (ce && vld[LAT-1]),
    .in_data   (res),
    .full      (full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {out_res.mapped_y, out_res.mapped_x};
  assign m_axis_tuser = out_res.saturated;

endmodule
